// ===== rtl/fat_chain_block_allocator_defines.svh =====
// Assertion macros used by the allocator top level.
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_DEFINES_SVH
// Condition in one cycle implies the consequence in the same cycle.
`define FCBA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fcba assertion failed");
// Condition in one cycle implies the consequence in the next cycle.
`define FCBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fcba assertion failed");
`endif

// ===== rtl/fcba_pkg.sv =====
// Shared constants and codes of the FAT chain block allocator.
package fcba_pkg;
	localparam int NUM_BLOCKS_DEF   = 256;
	localparam int DIR_SLOTS_DEF    = 11;
	localparam int TABLE_BLOCKS_DEF = 11;

	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_FIRST  = 3'd2;
	localparam logic [2:0] OP_APPEND = 3'd3;
	localparam logic [2:0] OP_DELETE = 3'd4;
	localparam logic [2:0] OP_NEXT   = 3'd5;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_DIR_FULL    = 3'd1,
		ST_NO_FILE     = 3'd2,
		ST_DISK_FULL   = 3'd3,
		ST_NOT_IN_FILE = 3'd4
	} status_t;
endpackage

// ===== rtl/fcba_link_ram.sv =====
// Link table memory: one write port, one read port with registered data.
module fcba_link_ram #(
	parameter int DEPTH = fcba_pkg::NUM_BLOCKS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);
	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/fat_chain_block_allocator.sv =====
// Top level of the FAT chain block allocator: sequencer, directory and link table.
// After reset the block formats its link table, one entry a cycle, with busy high. A
// request is taken when start is high and busy low; its single result appears for one
// cycle with done high, and busy stays high until then. Every valid request first
// scans the directory one slot a cycle. Create, remove and first block then finish at
// once; append takes the head of the free list, unlinks it, clears its link and walks
// the file's chain to hang it on the end; delete and next walk the chain to the named
// block through the one read port of the table, then next reads its link and delete
// unlinks it and puts it back on the free list. An unused operation code gives its
// result in the cycle after it is taken, and busy stays low.
// Results cannot be held off: the receiver must take each one in its strobe cycle.
`include "fat_chain_block_allocator_defines.svh"
module fat_chain_block_allocator #(
	parameter int NUM_BLOCKS   = fcba_pkg::NUM_BLOCKS_DEF,
	parameter int DIR_SLOTS    = fcba_pkg::DIR_SLOTS_DEF,
	parameter int TABLE_BLOCKS = fcba_pkg::TABLE_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [39:0] name_key,
	input  logic [7:0]  block_number,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  value
);
	localparam int BW    = $clog2(NUM_BLOCKS);
	localparam int CW    = (BW > 8) ? BW : 8;
	localparam int SW    = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
	localparam int START = TABLE_BLOCKS + 2;

	typedef enum logic [3:0] {
		S_FMT, S_IDLE, S_SCAN,
		S_AP_HEAD, S_AP_HD2, S_AP_NX2, S_AP_CLR, S_AP_WALK, S_AP_W2,
		S_CH_CHK, S_CH_NXT, S_CH_BN, S_CH_BN2, S_DL_HEAD, S_DL_H2, S_DL_FIN
	} state_t;

	state_t            state_q;
	logic [BW-1:0]     fmt_q;
	logic [2:0]        op_q;
	logic [39:0]       key_q;
	logic [CW-1:0]     bn_q;
	logic [SW-1:0]     idx_q;
	logic [SW-1:0]     slot_q;
	logic [BW-1:0]     cur_q;
	logic [BW-1:0]     prev_q;
	logic              prevv_q;
	logic [BW-1:0]     a_q;
	logic              done_q;
	fcba_pkg::status_t status_q;
	logic [7:0]        value_q;

	logic              used_q  [DIR_SLOTS];
	logic [39:0]       name_q  [DIR_SLOTS];
	logic [BW-1:0]     first_q [DIR_SLOTS];

	logic              we_c;
	logic [BW-1:0]     waddr_c;
	logic [BW-1:0]     wdata_c;
	logic [BW-1:0]     raddr_c;
	logic [BW-1:0]     rdata;
	logic [BW-1:0]     fmt_c;
	logic [BW-1:0]     bn_blk;

	function automatic logic [7:0] blk8(logic [BW-1:0] b);
		logic [CW-1:0] e;
		e = CW'(b);
		return e[7:0];
	endfunction

	assign bn_blk = bn_q[BW-1:0];

	fcba_link_ram #(.DEPTH(NUM_BLOCKS), .AW(BW)) u_ram (
		.clk(clk), .we(we_c), .waddr(waddr_c), .wdata(wdata_c),
		.raddr(raddr_c), .rdata(rdata)
	);

	always_comb begin
		if (fmt_q == '0) begin
			fmt_c = (START < NUM_BLOCKS) ? BW'(START) : '0;
		end else if (fmt_q == BW'(NUM_BLOCKS - 1)) begin
			fmt_c = '0;
		end else if (32'(fmt_q) >= 32'(START)) begin
			fmt_c = fmt_q + BW'(1);
		end else begin
			fmt_c = BW'(1);
		end
	end

	always_comb begin
		we_c    = 1'b0;
		waddr_c = '0;
		wdata_c = '0;
		raddr_c = '0;
		unique case (state_q)
			S_FMT: begin
				we_c    = 1'b1;
				waddr_c = fmt_q;
				wdata_c = fmt_c;
			end
			S_AP_HD2: raddr_c = rdata;
			S_AP_NX2: begin
				we_c    = 1'b1;
				wdata_c = rdata;
			end
			S_AP_CLR: begin
				we_c    = 1'b1;
				waddr_c = a_q;
			end
			S_AP_WALK: raddr_c = cur_q;
			S_AP_W2: begin
				we_c    = (rdata == '0);
				waddr_c = cur_q;
				wdata_c = a_q;
			end
			S_CH_CHK: raddr_c = cur_q;
			S_CH_BN: raddr_c = bn_blk;
			S_CH_BN2: begin
				we_c    = (op_q == fcba_pkg::OP_DELETE) && prevv_q;
				waddr_c = prev_q;
				wdata_c = rdata;
			end
			S_DL_H2: begin
				we_c    = 1'b1;
				waddr_c = bn_blk;
				wdata_c = rdata;
			end
			S_DL_FIN: begin
				we_c    = 1'b1;
				wdata_c = bn_blk;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FMT;
			fmt_q   <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < DIR_SLOTS; i++) begin
				used_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				S_FMT: begin
					fmt_q <= fmt_q + BW'(1);
					if (fmt_q == BW'(NUM_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					// Every other state is entered with done low and sets it only on
					// its way back here, so the strobe is cleared in this state alone.
					done_q <= start && (operation > fcba_pkg::OP_NEXT);
					if (start) begin
						op_q  <= operation;
						key_q <= name_key;
						bn_q  <= CW'(block_number);
						idx_q <= '0;
						if (operation > fcba_pkg::OP_NEXT) begin
							status_q <= fcba_pkg::ST_OK;
							value_q  <= '0;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + SW'(1);
					if (op_q == fcba_pkg::OP_CREATE) begin
						if (!used_q[idx_q]) begin
							used_q[idx_q]  <= 1'b1;
							name_q[idx_q]  <= key_q;
							first_q[idx_q] <= '0;
							done_q   <= 1'b1;
							status_q <= fcba_pkg::ST_OK;
							value_q  <= '0;
							state_q  <= S_IDLE;
						end else if (idx_q == SW'(DIR_SLOTS - 1)) begin
							done_q   <= 1'b1;
							status_q <= fcba_pkg::ST_DIR_FULL;
							value_q  <= '0;
							state_q  <= S_IDLE;
						end
					end else if (used_q[idx_q] && name_q[idx_q] == key_q) begin
						slot_q  <= idx_q;
						cur_q   <= first_q[idx_q];
						prevv_q <= 1'b0;
						case (op_q)
							fcba_pkg::OP_REMOVE: begin
								used_q[idx_q] <= 1'b0;
								done_q   <= 1'b1;
								status_q <= fcba_pkg::ST_OK;
								value_q  <= '0;
								state_q  <= S_IDLE;
							end
							fcba_pkg::OP_FIRST: begin
								done_q   <= 1'b1;
								status_q <= fcba_pkg::ST_OK;
								value_q  <= blk8(first_q[idx_q]);
								state_q  <= S_IDLE;
							end
							fcba_pkg::OP_APPEND: state_q <= S_AP_HEAD;
							default: state_q <= S_CH_CHK;
						endcase
					end else if (idx_q == SW'(DIR_SLOTS - 1)) begin
						done_q   <= 1'b1;
						status_q <= fcba_pkg::ST_NO_FILE;
						value_q  <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_AP_HEAD: state_q <= S_AP_HD2;
				S_AP_HD2: begin
					if (rdata == '0) begin
						done_q   <= 1'b1;
						status_q <= fcba_pkg::ST_DISK_FULL;
						value_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						a_q     <= rdata;
						state_q <= S_AP_NX2;
					end
				end
				S_AP_NX2: state_q <= S_AP_CLR;
				S_AP_CLR: begin
					if (first_q[slot_q] == '0) begin
						first_q[slot_q] <= a_q;
						done_q   <= 1'b1;
						status_q <= fcba_pkg::ST_OK;
						value_q  <= blk8(a_q);
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_AP_WALK;
					end
				end
				S_AP_WALK: state_q <= S_AP_W2;
				S_AP_W2: begin
					if (rdata == '0) begin
						done_q   <= 1'b1;
						status_q <= fcba_pkg::ST_OK;
						value_q  <= blk8(a_q);
						state_q  <= S_IDLE;
					end else begin
						cur_q   <= rdata;
						state_q <= S_AP_WALK;
					end
				end
				S_CH_CHK: begin
					if (cur_q == '0) begin
						done_q   <= 1'b1;
						status_q <= fcba_pkg::ST_NOT_IN_FILE;
						value_q  <= '0;
						state_q  <= S_IDLE;
					end else if (CW'(cur_q) == bn_q) begin
						state_q <= S_CH_BN;
					end else begin
						state_q <= S_CH_NXT;
					end
				end
				S_CH_NXT: begin
					prev_q  <= cur_q;
					prevv_q <= 1'b1;
					cur_q   <= rdata;
					state_q <= S_CH_CHK;
				end
				S_CH_BN: state_q <= S_CH_BN2;
				S_CH_BN2: begin
					if (op_q == fcba_pkg::OP_NEXT) begin
						done_q   <= 1'b1;
						status_q <= fcba_pkg::ST_OK;
						value_q  <= blk8(rdata);
						state_q  <= S_IDLE;
					end else begin
						if (!prevv_q) begin
							first_q[slot_q] <= rdata;
						end
						state_q <= S_DL_HEAD;
					end
				end
				S_DL_HEAD: state_q <= S_DL_H2;
				S_DL_H2: state_q <= S_DL_FIN;
				S_DL_FIN: begin
					done_q   <= 1'b1;
					status_q <= fcba_pkg::ST_OK;
					value_q  <= blk8(bn_blk);
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign value  = value_q;

	`FCBA_ASSERT_NEXT(a_start_busy, start && !busy && operation <= fcba_pkg::OP_NEXT, busy)
	`FCBA_ASSERT_NOW(a_done_idle, done, !busy)
	`FCBA_ASSERT_NOW(a_err_zero, done && status != fcba_pkg::ST_OK, value == 8'd0)
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the FAT chain block allocator: directed and random requests.
module testbench;
	import fcba_pkg::*;

	localparam int NBLK   = NUM_BLOCKS_DEF;
	localparam int NSLOT  = DIR_SLOTS_DEF;
	localparam int NTABLE = TABLE_BLOCKS_DEF;
	localparam logic [39:0] NAME_X = 40'h7878787878;
	localparam logic [2:0] OP_UNUSED6 = 3'd6;
	localparam logic [2:0] OP_UNUSED7 = 3'd7;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  operation = '0;
	logic [39:0] name_key = '0;
	logic [7:0]  block_number = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  value;

	// Predicted state of the directory and the link table.
	logic        dir_used [NSLOT];
	logic [39:0] dir_name [NSLOT];
	logic [7:0]  dir_first [NSLOT];
	logic [7:0]  links [NBLK];

	status_t     pending_status [$];
	logic [7:0]  pending_value [$];
	int          errors = 0;
	int          cycles = 0;
	bit          quiet = 0;
	logic [39:0] key_pool [6];

	fat_chain_block_allocator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .name_key(name_key), .block_number(block_number),
		.done(done), .status(status), .value(value)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void format_table();
		for (int i = 0; i < NSLOT; i++) begin
			dir_used[i] = 1'b0;
			dir_name[i] = '0;
			dir_first[i] = '0;
		end
		for (int i = 1; i < NBLK; i++)
			links[i] = (i >= NTABLE + 2) ? 8'(i + 1) : 8'd1;
		links[NBLK - 1] = '0;
		links[0] = 8'(NTABLE + 2);
	endfunction

	function automatic int find_file(input logic [39:0] key);
		for (int i = 0; i < NSLOT; i++)
			if (dir_used[i] && dir_name[i] == key)
				return i;
		return -1;
	endfunction

	function automatic bit chain_has(input logic [7:0] first, input logic [7:0] b);
		logic [7:0] cur;
		int steps;
		cur = first;
		steps = 0;
		while (cur != 0 && steps < NBLK) begin
			if (cur == b)
				return 1;
			cur = links[cur];
			steps++;
		end
		return 0;
	endfunction

	// Applies one request to the predicted state and returns its result.
	function automatic void allocate_predict(input logic [2:0] op, input logic [39:0] key,
			input logic [7:0] bn, output status_t st, output logic [7:0] val);
		int s;
		logic [7:0] a;
		logic [7:0] cur;
		st = ST_OK;
		val = '0;
		s = find_file(key);
		case (op)
			OP_CREATE: begin
				st = ST_DIR_FULL;
				for (int i = 0; i < NSLOT; i++) begin
					if (!dir_used[i]) begin
						dir_used[i] = 1'b1;
						dir_name[i] = key;
						dir_first[i] = '0;
						st = ST_OK;
						break;
					end
				end
			end
			OP_REMOVE: begin
				if (s < 0) begin
					st = ST_NO_FILE;
				end else begin
					dir_used[s] = 1'b0;
					dir_name[s] = '0;
					dir_first[s] = '0;
				end
			end
			OP_FIRST: begin
				if (s < 0) st = ST_NO_FILE;
				else val = dir_first[s];
			end
			OP_APPEND: begin
				if (s < 0) begin
					st = ST_NO_FILE;
				end else if (links[0] == 0) begin
					st = ST_DISK_FULL;
				end else begin
					a = links[0];
					links[0] = links[a];
					links[a] = '0;
					if (dir_first[s] == 0) begin
						dir_first[s] = a;
					end else begin
						cur = dir_first[s];
						while (links[cur] != 0)
							cur = links[cur];
						links[cur] = a;
					end
					val = a;
				end
			end
			OP_DELETE: begin
				if (s < 0) begin
					st = ST_NO_FILE;
				end else if (!chain_has(dir_first[s], bn)) begin
					st = ST_NOT_IN_FILE;
				end else begin
					if (dir_first[s] == bn) begin
						dir_first[s] = links[bn];
					end else begin
						cur = dir_first[s];
						while (links[cur] != bn)
							cur = links[cur];
						links[cur] = links[bn];
					end
					links[bn] = links[0];
					links[0] = bn;
					val = bn;
				end
			end
			OP_NEXT: begin
				if (s < 0) st = ST_NO_FILE;
				else if (!chain_has(dir_first[s], bn)) st = ST_NOT_IN_FILE;
				else val = links[bn];
			end
			default: ;
		endcase
	endfunction

	// Returns a random member of the file's chain, or a random block if it has none.
	function automatic logic [7:0] pick_member(input logic [39:0] key);
		int s;
		int n;
		int k;
		logic [7:0] cur;
		s = find_file(key);
		if (s < 0 || dir_first[s] == 0)
			return 8'($urandom);
		n = 0;
		cur = dir_first[s];
		while (cur != 0) begin
			n++;
			cur = links[cur];
		end
		k = $urandom_range(0, n - 1);
		cur = dir_first[s];
		repeat (k) cur = links[cur];
		return cur;
	endfunction

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) n = 0;
		else if (r < 93) n = $urandom_range(1, 3);
		else n = $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Sends one request and records its expected result once the block takes it.
	task automatic send_request(input logic [2:0] op, input logic [39:0] key,
			input logic [7:0] bn);
		status_t st;
		logic [7:0] val;
		idle_gap();
		start <= 1'b1;
		operation <= op;
		name_key <= key;
		block_number <= bn;
		do @(posedge clk); while (busy);
		allocate_predict(op, key, bn, st, val);
		pending_status = {pending_status, st};
		pending_value = {pending_value, val};
	endtask

	task automatic wait_drained();
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_status.size() == 0) begin
				$error("result with no request outstanding: status %0d value %0d",
					status, value);
				errors++;
			end else begin
				if (status !== pending_status[0]) begin
					$error("status: expected %0d, actual %0d", pending_status[0], status);
					errors++;
				end
				if (value !== pending_value[0]) begin
					$error("value: expected %0d, actual %0d", pending_value[0], value);
					errors++;
				end
				void'(pending_status.pop_front());
				void'(pending_value.pop_front());
			end
		end
	end

	task automatic test_directed();
		logic [39:0] ones;
		ones = '1;
		send_request(OP_FIRST, NAME_X, 8'd0);
		send_request(OP_APPEND, NAME_X, 8'd0);
		send_request(OP_DELETE, NAME_X, 8'd20);
		send_request(OP_NEXT, NAME_X, 8'd20);
		send_request(OP_REMOVE, NAME_X, 8'd0);
		send_request(OP_CREATE, NAME_X, 8'd0);
		send_request(OP_NEXT, NAME_X, 8'd0);
		send_request(OP_APPEND, NAME_X, 8'd0);
		send_request(OP_APPEND, NAME_X, 8'd0);
		send_request(OP_APPEND, NAME_X, 8'd0);
		send_request(OP_FIRST, NAME_X, 8'd0);
		send_request(OP_NEXT, NAME_X, 8'd14);
		send_request(OP_NEXT, NAME_X, 8'd15);
		send_request(OP_DELETE, NAME_X, 8'd0);
		send_request(OP_DELETE, NAME_X, 8'd255);
		send_request(OP_DELETE, NAME_X, 8'd14);
		send_request(OP_DELETE, NAME_X, 8'd13);
		// A duplicate name takes a second slot; lookups still see the first one.
		send_request(OP_CREATE, NAME_X, 8'd0);
		send_request(OP_CREATE, 40'd0, 8'd0);
		send_request(OP_APPEND, 40'd0, 8'd0);
		send_request(OP_CREATE, ones, 8'd0);
		send_request(OP_APPEND, ones, 8'hff);
		send_request(OP_UNUSED6, ones, 8'hff);
		send_request(OP_UNUSED7, 40'd0, 8'd0);
		send_request(OP_REMOVE, NAME_X, 8'd0);
	endtask

	task automatic test_disk_full();
		int s;
		int k;
		send_request(OP_CREATE, NAME_X, 8'd0);
		quiet = 1;
		while (links[0] != 0)
			send_request(OP_APPEND, NAME_X, 8'd0);
		quiet = 0;
		send_request(OP_APPEND, NAME_X, 8'd0);
		send_request(OP_APPEND, 40'h0102030405, 8'd0);
		s = find_file(NAME_X);
		k = 0;
		while (s >= 0 && dir_first[s] != 0 && k < 40) begin
			if ($urandom_range(0, 3) == 0)
				send_request(OP_DELETE, NAME_X, pick_member(NAME_X));
			else
				send_request(OP_DELETE, NAME_X, dir_first[s]);
			s = find_file(NAME_X);
			k++;
		end
		// Removing the file leaks the rest of its chain, so the disk stays nearly full.
		send_request(OP_REMOVE, NAME_X, 8'd0);
	endtask

	task automatic test_directory_full();
		int s;
		while (find_file(40'hffffffffff) < 0 || dir_used[NSLOT - 1] == 0)
			send_request(OP_CREATE, 40'($urandom_range(0, 1) ? 40'hffffffffff : $urandom),
				8'd0);
		send_request(OP_CREATE, 40'h1122334455, 8'd0);
		s = 0;
		while (s >= 0) begin
			s = -1;
			for (int i = 0; i < NSLOT; i++)
				if (dir_used[i] && s < 0)
					s = i;
			if (s >= 0)
				send_request(OP_REMOVE, dir_name[s], 8'd0);
		end
	endtask

	task automatic test_random();
		int r;
		logic [39:0] key;
		logic [2:0] op;
		logic [7:0] bn;
		for (int i = 0; i < NSLOT; i++)
			key_pool[i % 6] = 40'({$urandom, $urandom});
		key_pool[0] = NAME_X;
		for (int n = 0; n < 120; n++) begin
			if (n % 60 == 0) quiet = ~quiet;
			if (n == 60) begin
				start <= 1'b0;
				wait_drained();
			end
			key = ($urandom_range(0, 19) == 0) ? 40'({$urandom, $urandom}) :
				key_pool[$urandom_range(0, 5)];
			r = $urandom_range(0, 99);
			if (r < 12) op = OP_CREATE;
			else if (r < 18) op = OP_REMOVE;
			else if (r < 26) op = OP_FIRST;
			else if (r < 56) op = OP_APPEND;
			else if (r < 76) op = OP_DELETE;
			else if (r < 96) op = OP_NEXT;
			else op = $urandom_range(0, 1) ? OP_UNUSED6 : OP_UNUSED7;
			bn = ($urandom_range(0, 4) == 0) ? 8'($urandom) : pick_member(key);
			send_request(op, key, bn);
		end
	endtask

	initial begin
		format_table();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_disk_full();
		test_directory_full();
		test_random();
		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_status.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
